// File: design/itp_pkg.sv
// Shared types, character codes and precedence function for the infix-to-postfix converter.
// No dependencies; every other design file except itp_ram refers to this package by scoped names.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int CHAR_W          = 8;
    localparam int LIMIT_W         = 5;
    localparam int PREC_W          = 2;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = 1;

    localparam logic [LIMIT_W-1:0]   LIMIT_RST = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_STACK_LIMIT = 1'b0;

    localparam logic [CHAR_W-1:0] CH_POW = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_MUL = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ADD = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
        logic              overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SEL_CHAR,
        SEL_TOP,
        SEL_MARK
    } t_emit_sel;

    typedef struct packed {
        logic      accept;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      push;
        logic      pop;
    } t_cmd;

    typedef struct packed {
        logic is_op;
        logic pop_ok;
        logic can_push;
        logic count_nz;
        logic count_one;
        logic last;
        logic out_free;
    } t_status;

    function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
        logic [PREC_W-1:0] p;
        case (c)
            CH_POW:  p = 2'd3;
            CH_MUL:  p = 2'd2;
            CH_DIV:  p = 2'd2;
            CH_ADD:  p = 2'd1;
            CH_SUB:  p = 2'd1;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// File: design/infix_to_postfix_converter_core.sv
// Top level of the infix-to-postfix converter: state machine plus datapath.
// Depends on itp_pkg, itp_ctrl, itp_dp (and itp_ram below it).
//
// Converts one ASCII character per request into postfix results, one result per cycle
// at most. An operand is accepted, then emitted. An operator is accepted, then pops
// stacked operators, then is pushed or emits an overflow marker. A final character
// then flushes every operator left on the stack. The pop and flush loops run one entry
// per cycle while the output is not stalled, through the stack RAM's single read port,
// with the top entry kept in a register. The stack_limit register at byte address 0 is
// to be written through the APB port only while idle; the block itself does not enforce
// it. Stack contents need no clearing after reset.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  itp_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output itp_pkg::t_out_item             o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [itp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [itp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [itp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    itp_pkg::t_cmd    cmd;
    itp_pkg::t_status status;

    assign pready = 1'b1;

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// File: design/itp_ram.sv
// Generic single-port-write, single-port-read RAM with registered, write-first read.
// No dependencies.
module itp_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_we && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/itp_ctrl.sv
// Sequencing state machine: accept, pop loop, push or overflow marker, flush.
// Depends on itp_pkg; drives itp_dp through t_cmd and reads t_status.
module itp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  itp_pkg::t_status i_status,
    output itp_pkg::t_cmd    o_cmd
);

    itp_pkg::t_state r_state;
    itp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.emit_sel   = itp_pkg::SEL_CHAR;
        o_in_ready       = 1'b0;
        case (r_state)
            itp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = itp_pkg::S_WORK;
                end
            end
            itp_pkg::S_WORK: begin
                if (!i_status.is_op) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_sel  = itp_pkg::SEL_CHAR;
                        o_cmd.emit_last = i_status.last && !i_status.count_nz;
                        n_state = (i_status.last && i_status.count_nz) ?
                                  itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
                    end
                end else if (i_status.pop_ok) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = itp_pkg::SEL_TOP;
                        o_cmd.pop      = 1'b1;
                    end
                end else if (i_status.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state = i_status.last ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = itp_pkg::SEL_MARK;
                    o_cmd.emit_last = i_status.last && !i_status.count_nz;
                    n_state = (i_status.last && i_status.count_nz) ?
                              itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
                end
            end
            itp_pkg::S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = itp_pkg::SEL_TOP;
                    o_cmd.pop       = 1'b1;
                    o_cmd.emit_last = i_status.count_one;
                    if (i_status.count_one) begin
                        n_state = itp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = itp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: design/itp_dp.sv
// Datapath: request latch, top-of-stack register, stack RAM, count, limit register, output stage.
// Depends on itp_pkg and itp_ram; controlled by itp_ctrl through t_cmd / t_status.
module itp_dp #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  itp_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output itp_pkg::t_out_item                  o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [itp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [itp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [itp_pkg::APB_DATA_W-1:0]      prdata,
    input  itp_pkg::t_cmd                       i_cmd,
    output itp_pkg::t_status                    o_status
);

    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CMP_W = (CW > itp_pkg::LIMIT_W) ? CW : itp_pkg::LIMIT_W;

    logic [itp_pkg::CHAR_W-1:0]  r_char;
    logic                        r_last;
    logic [itp_pkg::CHAR_W-1:0]  r_top;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [itp_pkg::LIMIT_W-1:0] r_limit;
    itp_pkg::t_out_item          r_out;
    itp_pkg::t_out_item          n_out;
    logic                        r_out_valid;

    logic [itp_pkg::CHAR_W-1:0]  ram_rd_data;
    logic [itp_pkg::PREC_W-1:0]  prec_in;
    logic [itp_pkg::PREC_W-1:0]  prec_top;
    logic [CMP_W-1:0]            count_ext;
    logic                        cfg_wr;
    logic [itp_pkg::REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[itp_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == itp_pkg::REG_STACK_LIMIT);
    assign prdata  = (reg_idx == itp_pkg::REG_STACK_LIMIT) ?
                     itp_pkg::APB_DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= itp_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            r_limit <= pwdata[itp_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in.in_char;
            r_last <= i_in.in_last;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= r_char;
        end else if (i_cmd.pop) begin
            r_top <= ram_rd_data;
        end
    end

    itp_ram #(
        .WIDTH (itp_pkg::CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.push && (r_count != '0)),
        .i_wr_addr (AW'(r_count - CW'(1))),
        .i_wr_data (r_top),
        .i_rd_addr (AW'(n_count - CW'(2))),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_out = r_out;
        if (i_cmd.emit) begin
            n_out.out_last = i_cmd.emit_last;
            n_out.overflow = 1'b0;
            case (i_cmd.emit_sel)
                itp_pkg::SEL_CHAR: n_out.out_char = r_char;
                itp_pkg::SEL_TOP:  n_out.out_char = r_top;
                itp_pkg::SEL_MARK: begin
                    n_out.out_char = itp_pkg::CH_NUL;
                    n_out.overflow = 1'b1;
                end
                default:           n_out.out_char = r_char;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign prec_in   = itp_pkg::prec_of(r_char);
    assign prec_top  = itp_pkg::prec_of(r_top);
    assign count_ext = CMP_W'(r_count);

    assign o_status.is_op     = (prec_in != '0);
    assign o_status.count_nz  = (r_count != '0);
    assign o_status.count_one = (r_count == CW'(1));
    assign o_status.pop_ok    = (r_count != '0) &&
                                ((prec_top > prec_in) ||
                                 ((prec_top == prec_in) && (r_char != itp_pkg::CH_POW)));
    assign o_status.can_push  = (count_ext < CMP_W'(r_limit)) &&
                                (count_ext < CMP_W'(STACK_DEPTH));
    assign o_status.last      = r_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

// File: design/itp_chk.sv
// Port-level checker for the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg.
module itp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input itp_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input itp_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    a_marker_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overflow) |-> (o_out.out_char == itp_pkg::CH_NUL))
        else $error("overflow marker carries a character");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one in progress");

endmodule

bind infix_to_postfix_converter_core itp_chk u_itp_chk (.*);

// File: dv/tb_infix_to_postfix_converter_core.sv
// Self-checking testbench for infix_to_postfix_converter_core: drives infix characters,
// predicts the postfix stream with an operator stack of its own and checks every result.
// Depends on itp_pkg and the converter RTL; sets stack_limit through the APB port.
module tb_infix_to_postfix_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    itp_pkg::t_in_item              i_in        = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    itp_pkg::t_out_item             o_out;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [itp_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [itp_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [itp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    itp_pkg::t_in_item   char_q[$];
    itp_pkg::t_out_item  postfix_q[$];
    logic [7:0]      op_stack[STACK_DEPTH];
    int unsigned     op_depth = 0;
    logic [4:0]      limit_reg = itp_pkg::LIMIT_RST;
    logic [7:0]      op_codes[5] = '{itp_pkg::CH_POW, itp_pkg::CH_MUL, itp_pkg::CH_DIV,
                                     itp_pkg::CH_ADD, itp_pkg::CH_SUB};
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     err_count = 0;
    int unsigned     requests_sent = 0;
    int unsigned     results_seen = 0;
    int unsigned     limits_tried = 0;
    int unsigned     quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned char_rank(input logic [7:0] c);
        case (c)
            itp_pkg::CH_POW:                  return 3;
            itp_pkg::CH_MUL, itp_pkg::CH_DIV: return 2;
            itp_pkg::CH_ADD, itp_pkg::CH_SUB: return 1;
            default:                          return 0;
        endcase
    endfunction

    function automatic void push_result(input logic [7:0] c, input logic ovf);
        itp_pkg::t_out_item r;
        r.out_char = c;
        r.out_last = 1'b0;
        r.overflow = ovf;
        postfix_q.push_back(r);
    endfunction

    function automatic void convert_char(input itp_pkg::t_in_item it);
        int unsigned lim;
        int unsigned rank;
        int unsigned top_rank;
        int          n;
        lim  = (limit_reg > STACK_DEPTH) ? STACK_DEPTH : limit_reg;
        rank = char_rank(it.in_char);
        n    = 0;
        if (rank == 0) begin
            push_result(it.in_char, 1'b0);
            n++;
        end else begin
            while (op_depth > 0) begin
                top_rank = char_rank(op_stack[op_depth-1]);
                if (top_rank > rank ||
                    (top_rank == rank && it.in_char != itp_pkg::CH_POW)) begin
                    push_result(op_stack[op_depth-1], 1'b0);
                    op_depth--;
                    n++;
                end else begin
                    break;
                end
            end
            if (op_depth < lim) begin
                op_stack[op_depth] = it.in_char;
                op_depth++;
            end else begin
                push_result(itp_pkg::CH_NUL, 1'b1);
                n++;
            end
        end
        if (it.in_last) begin
            while (op_depth > 0) begin
                push_result(op_stack[op_depth-1], 1'b0);
                op_depth--;
                n++;
            end
            if (n > 0)
                postfix_q[postfix_q.size()-1].out_last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // driver: hold the request until accepted, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                convert_char(i_in);
                requests_sent++;
            end
            if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in       <= char_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        itp_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (postfix_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(o_out), 0);
                end else begin
                    want = postfix_q.pop_front();
                    if (o_out.out_char !== want.out_char)
                        report_mismatch("out_char", int'(o_out.out_char),
                                        int'(want.out_char));
                    if (o_out.out_last !== want.out_last)
                        report_mismatch("out_last", int'(o_out.out_last),
                                        int'(want.out_last));
                    if (o_out.overflow !== want.overflow)
                        report_mismatch("overflow", int'(o_out.overflow),
                                        int'(want.overflow));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: %0d cycles without a handshake", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic cfg_access(input logic wr, input logic [itp_pkg::APB_DATA_W-1:0] wdata,
                              output logic [itp_pkg::APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {itp_pkg::REG_STACK_LIMIT, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limit(input logic [4:0] value);
        logic [itp_pkg::APB_DATA_W-1:0] rd;
        cfg_access(1'b1, itp_pkg::APB_DATA_W'(value), rd);
        limit_reg = value;
        limits_tried++;
        cfg_access(1'b0, '0, rd);
        if (rd !== itp_pkg::APB_DATA_W'(value))
            report_mismatch("stack_limit readback", int'(rd), int'(value));
    endtask

    // drain: wait until no request is pending and every result has come
    task automatic drain();
        do @(posedge i_clk);
        while (char_q.size() != 0 || i_in_valid || postfix_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_item(input logic [7:0] c, input logic last);
        itp_pkg::t_in_item it;
        it.in_char = c;
        it.in_last = last;
        char_q.push_back(it);
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            add_item(s[k], k == s.len() - 1);
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h61, 8'h7A));
        do c = 8'($urandom);
        while (char_rank(c) != 0);
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        return op_codes[$urandom_range(0, 4)];
    endfunction

    task automatic random_items(input int count);
        int made;
        int n_ops;
        int kind;
        int len;
        bit pow_only;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                pow_only = ($urandom_range(0, 7) == 0);
                n_ops = pow_only ? $urandom_range(15, 20) : $urandom_range(0, 6);
                add_item(pick_operand(), n_ops == 0);
                for (int k = 0; k < n_ops; k++) begin
                    add_item(pow_only ? itp_pkg::CH_POW : pick_operator(), 1'b0);
                    add_item(pick_operand(), k == n_ops - 1);
                end
                made += 2 * n_ops + 1;
            end else if (kind < 9) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_item($urandom_range(0, 1) ? pick_operator() : pick_operand(),
                             k == len - 1 && $urandom_range(0, 3) != 0);
                made += len;
            end else begin
                add_item(8'($urandom), 1'($urandom));
                made++;
            end
        end
        drain();
    endtask

    initial begin
        logic [itp_pkg::APB_DATA_W-1:0] rd;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_access(1'b0, '0, rd);
        if (rd !== itp_pkg::APB_DATA_W'(itp_pkg::LIMIT_RST))
            report_mismatch("stack_limit after reset", int'(rd), int'(itp_pkg::LIMIT_RST));

        send_idle_pct = 10;
        recv_idle_pct = 46;
        set_limit(5'd16);
        add_text("a+b*c^d^e-f/g");
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        add_text("a-");
        drain();
        set_limit(5'd1);
        add_text("a*b+c^d");
        drain();
        set_limit(5'd0);
        add_text("+");
        drain();

        set_limit(5'd31);
        random_items(40);

        send_idle_pct = 46;
        recv_idle_pct = 10;
        set_limit(5'd5);
        random_items(40);
        set_limit(5'd2);
        random_items(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(5'd16);
        random_items(40);
        set_limit(5'($urandom_range(1, 16)));
        random_items(30);

        $display("sent %0d characters, checked %0d postfix results", requests_sent,
                 results_seen);
        $display("stack limits tried: %0d, including zero, one, full depth and above",
                 limits_tried);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
